[src/pairwise_concurrency_profiler_unit_macros.svh]
// ----------------------------------------------------------------------------
// Pairwise concurrency profiler - assertion macros
// Shared concurrent assertion forms used by the profiler RTL.
// ----------------------------------------------------------------------------
`ifndef PAIRWISE_CONCURRENCY_PROFILER_UNIT_MACROS_SVH
`define PAIRWISE_CONCURRENCY_PROFILER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcp: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcp: assertion failed");

`endif

[src/pcp_pkg.sv]
// ----------------------------------------------------------------------------
// Pairwise concurrency profiler - package
// Field widths, operation codes and table select codes.
// ----------------------------------------------------------------------------
package pcp_pkg;

  localparam int PROC_MASK_W = 8;
  localparam int CHAN_MASK_W = 8;
  localparam int UNIT_MASK_W = 4;
  localparam int SEL_W       = 3;
  localparam int IDX_W       = 3;
  localparam int VALUE_W     = 32;
  localparam int WIDE_W      = 64;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef enum logic [SEL_W-1:0] {
    SEL_PROC_RUN  = 3'd0,
    SEL_PROC_LIVE = 3'd1,
    SEL_CHAN_RUN  = 3'd2,
    SEL_CHAN_LIVE = 3'd3,
    SEL_UNIT_PAIR = 3'd4,
    SEL_HIST      = 3'd5,
    SEL_SAMPLES   = 3'd6
  } sel_t;

endpackage

[src/pcp_sat_counter.sv]
// ----------------------------------------------------------------------------
// Pairwise concurrency profiler - saturating counter lane
// One event counter that sticks at its all-ones value.
// ----------------------------------------------------------------------------
module pcp_sat_counter #(
  parameter int CNT_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             inc,
  output logic [CNT_W-1:0] count
);

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (inc && (cnt_r != '1)) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign count = cnt_r;

endmodule

[src/pcp_pair_table.sv]
// ----------------------------------------------------------------------------
// Pairwise concurrency profiler - pair counter table
// One counter lane per member pair i<k, plus a registered read port.
// ----------------------------------------------------------------------------
module pcp_pair_table #(
  parameter int N      = 8,
  parameter int MASK_W = 8,
  parameter int CNT_W  = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      sample,
  input  logic [MASK_W-1:0]         mask,
  input  logic                      rd_en,
  input  logic [pcp_pkg::IDX_W-1:0] rd_row,
  input  logic [pcp_pkg::IDX_W-1:0] rd_col,
  output logic [CNT_W-1:0]          rd_data
);
  import pcp_pkg::*;

  // Members past the mask width never become set, so no lanes for them.
  localparam int LN = (N < MASK_W) ? N : MASK_W;
  localparam int IW = $clog2(LN);

  logic [CNT_W-1:0] grid [LN][LN];
  logic [CNT_W-1:0] rd_sel;
  logic [CNT_W-1:0] rd_data_r;

  for (genvar i = 0; i < LN; i++) begin : g_row
    for (genvar k = 0; k < LN; k++) begin : g_col
      if (i < k) begin : g_lane
        pcp_sat_counter #(.CNT_W(CNT_W)) u_cnt (
          .clk   (clk),
          .rst_n (rst_n),
          .inc   (sample && mask[i] && mask[k]),
          .count (grid[i][k])
        );
      end else begin : g_none
        assign grid[i][k] = '0;
      end
    end
  end

  always_comb begin
    rd_sel = '0;
    if ((rd_row < LN) && (rd_col < LN)) begin
      rd_sel = grid[rd_row[IW-1:0]][rd_col[IW-1:0]];
    end
  end

  // Capture on read; payload only, no reset.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= rd_sel;
    end
  end

  assign rd_data = rd_data_r;

endmodule

[src/pairwise_concurrency_profiler_unit.sv]
// ----------------------------------------------------------------------------
// Pairwise concurrency profiler
// Counts co-running and co-live member pairs, active unit pairs, an active
// unit histogram and samples; returns one counter per read word.
// ----------------------------------------------------------------------------
// The block takes one input word per clock cycle while in_stall is low. A sample word (operation 0)
// updates every counter at once in its acceptance cycle: each pair of members
// owns its own saturating counter lane, so all tables count side by side and
// a sample produces no output word. A read word (operation 1) is captured in
// the acceptance cycle (each table latches the addressed counter, the index
// check is registered), merged by table select from the capture stage and
// loaded into the output register once that register is free. A read sees
// every sample accepted before it. in_stall rises only while a read waits in
// the capture stage and the output register is held by out_stall; otherwise
// words flow at one per cycle. All counters live in flip-flops that reset
// clears directly, so there is no clearing pass. Counters are COUNT_BITS wide
// and saturate at all ones; a read returns their low 32 bits.
// ----------------------------------------------------------------------------
`include "pairwise_concurrency_profiler_unit_macros.svh"

module pairwise_concurrency_profiler_unit #(
  parameter int NUM_PROCS    = 8,
  parameter int NUM_CHANNELS = 8,
  parameter int NUM_UNITS    = 4,
  parameter int COUNT_BITS   = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_operation,
  input  logic [pcp_pkg::PROC_MASK_W-1:0] in_proc_running,
  input  logic [pcp_pkg::PROC_MASK_W-1:0] in_proc_ready,
  input  logic [pcp_pkg::CHAN_MASK_W-1:0] in_chan_running,
  input  logic [pcp_pkg::CHAN_MASK_W-1:0] in_chan_ready,
  input  logic [pcp_pkg::UNIT_MASK_W-1:0] in_unit_active,
  input  logic [pcp_pkg::SEL_W-1:0]       in_table_select,
  input  logic [pcp_pkg::IDX_W-1:0]       in_row_index,
  input  logic [pcp_pkg::IDX_W-1:0]       in_col_index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pcp_pkg::VALUE_W-1:0]     out_count_value,
  output logic                            out_bad_index
);
  import pcp_pkg::*;

  // Histogram entries that can ever be hit: 0 .. active unit count.
  localparam int HU     = (NUM_UNITS < UNIT_MASK_W) ? NUM_UNITS : UNIT_MASK_W;
  localparam int HIST_N = HU + 1;
  localparam int HW     = $clog2(HIST_N);

  // --------------------------------------------------------------------------
  // Handshake and pipeline control
  // --------------------------------------------------------------------------
  logic in_accept;
  logic samp_acc;
  logic rd_acc;
  logic out_free;
  logic s1_adv;

  logic s1_v_r,  s1_v_nxt;
  logic out_v_r, out_v_nxt;

  assign out_free  = !out_v_r || !out_stall;
  assign s1_adv    = s1_v_r && out_free;
  // Hold the input only while a captured read cannot move on.
  assign in_stall  = s1_v_r && !out_free;
  assign in_accept = in_valid && !in_stall;
  assign samp_acc  = in_accept && (op_t'(in_operation) == OP_SAMPLE);
  assign rd_acc    = in_accept && (op_t'(in_operation) == OP_READ);

  // --------------------------------------------------------------------------
  // Pair counter tables (one lane per pair)
  // --------------------------------------------------------------------------
  logic [COUNT_BITS-1:0] proc_run_rd;
  logic [COUNT_BITS-1:0] proc_live_rd;
  logic [COUNT_BITS-1:0] chan_run_rd;
  logic [COUNT_BITS-1:0] chan_live_rd;
  logic [COUNT_BITS-1:0] unit_pair_rd;

  pcp_pair_table #(.N(NUM_PROCS), .MASK_W(PROC_MASK_W), .CNT_W(COUNT_BITS)) u_proc_run (
    .clk     (clk),
    .rst_n   (rst_n),
    .sample  (samp_acc),
    .mask    (in_proc_running),
    .rd_en   (rd_acc),
    .rd_row  (in_row_index),
    .rd_col  (in_col_index),
    .rd_data (proc_run_rd)
  );

  // A member is live when running or ready.
  pcp_pair_table #(.N(NUM_PROCS), .MASK_W(PROC_MASK_W), .CNT_W(COUNT_BITS)) u_proc_live (
    .clk     (clk),
    .rst_n   (rst_n),
    .sample  (samp_acc),
    .mask    (in_proc_running | in_proc_ready),
    .rd_en   (rd_acc),
    .rd_row  (in_row_index),
    .rd_col  (in_col_index),
    .rd_data (proc_live_rd)
  );

  pcp_pair_table #(.N(NUM_CHANNELS), .MASK_W(CHAN_MASK_W), .CNT_W(COUNT_BITS)) u_chan_run (
    .clk     (clk),
    .rst_n   (rst_n),
    .sample  (samp_acc),
    .mask    (in_chan_running),
    .rd_en   (rd_acc),
    .rd_row  (in_row_index),
    .rd_col  (in_col_index),
    .rd_data (chan_run_rd)
  );

  pcp_pair_table #(.N(NUM_CHANNELS), .MASK_W(CHAN_MASK_W), .CNT_W(COUNT_BITS)) u_chan_live (
    .clk     (clk),
    .rst_n   (rst_n),
    .sample  (samp_acc),
    .mask    (in_chan_running | in_chan_ready),
    .rd_en   (rd_acc),
    .rd_row  (in_row_index),
    .rd_col  (in_col_index),
    .rd_data (chan_live_rd)
  );

  pcp_pair_table #(.N(NUM_UNITS), .MASK_W(UNIT_MASK_W), .CNT_W(COUNT_BITS)) u_unit_pair (
    .clk     (clk),
    .rst_n   (rst_n),
    .sample  (samp_acc),
    .mask    (in_unit_active),
    .rd_en   (rd_acc),
    .rd_row  (in_row_index),
    .rd_col  (in_col_index),
    .rd_data (unit_pair_rd)
  );

  // --------------------------------------------------------------------------
  // Active unit histogram and sample counter
  // --------------------------------------------------------------------------
  logic [HW-1:0]         act_cnt;
  logic [COUNT_BITS-1:0] hist [HIST_N];
  logic [COUNT_BITS-1:0] hist_sel;
  logic [COUNT_BITS-1:0] hist_rd_r;
  logic [COUNT_BITS-1:0] samp_cnt;
  logic [COUNT_BITS-1:0] samp_rd_r;

  // Count active units; bits past NUM_UNITS are ignored.
  always_comb begin
    act_cnt = '0;
    for (int j = 0; j < HU; j++) begin
      act_cnt = act_cnt + HW'(in_unit_active[j]);
    end
  end

  for (genvar j = 0; j < HIST_N; j++) begin : g_hist
    pcp_sat_counter #(.CNT_W(COUNT_BITS)) u_hist (
      .clk   (clk),
      .rst_n (rst_n),
      .inc   (samp_acc && (act_cnt == HW'(j))),
      .count (hist[j])
    );
  end

  pcp_sat_counter #(.CNT_W(COUNT_BITS)) u_samples (
    .clk   (clk),
    .rst_n (rst_n),
    .inc   (samp_acc),
    .count (samp_cnt)
  );

  // Entries above the reachable count stay zero for ever.
  always_comb begin
    hist_sel = '0;
    if (in_row_index < HIST_N) begin
      hist_sel = hist[in_row_index[HW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_acc) begin
      hist_rd_r <= hist_sel;
      samp_rd_r <= samp_cnt;
    end
  end

  // --------------------------------------------------------------------------
  // Index check at capture
  // --------------------------------------------------------------------------
  sel_t sel_in;
  logic bad_in;
  sel_t sel_r;
  logic bad_r;

  assign sel_in = sel_t'(in_table_select);

  always_comb begin
    unique case (sel_in) inside
      SEL_PROC_RUN, SEL_PROC_LIVE: begin
        bad_in = (in_row_index >= in_col_index) || (in_col_index >= NUM_PROCS);
      end
      SEL_CHAN_RUN, SEL_CHAN_LIVE: begin
        bad_in = (in_row_index >= in_col_index) || (in_col_index >= NUM_CHANNELS);
      end
      SEL_UNIT_PAIR: begin
        bad_in = (in_row_index >= in_col_index) || (in_col_index >= NUM_UNITS);
      end
      SEL_HIST: begin
        bad_in = (in_row_index > NUM_UNITS);
      end
      SEL_SAMPLES: begin
        bad_in = 1'b0;
      end
      default: begin
        bad_in = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_acc) begin
      sel_r <= sel_in;
      bad_r <= bad_in;
    end
  end

  // --------------------------------------------------------------------------
  // Merge stage: pick the captured table word and load the output register
  // --------------------------------------------------------------------------
  logic [COUNT_BITS-1:0] merged;
  logic [WIDE_W-1:0]     merged_wide;
  logic [VALUE_W-1:0]    value_nxt;
  logic [VALUE_W-1:0]    out_val_r;
  logic                  out_bad_r;

  always_comb begin
    unique case (sel_r) inside
      SEL_PROC_RUN:  merged = proc_run_rd;
      SEL_PROC_LIVE: merged = proc_live_rd;
      SEL_CHAN_RUN:  merged = chan_run_rd;
      SEL_CHAN_LIVE: merged = chan_live_rd;
      SEL_UNIT_PAIR: merged = unit_pair_rd;
      SEL_HIST:      merged = hist_rd_r;
      SEL_SAMPLES:   merged = samp_rd_r;
      default:       merged = '0;
    endcase
  end

  // Keep the low 32 bits of the counter; zero on a bad index.
  assign merged_wide = WIDE_W'(merged);
  assign value_nxt   = bad_r ? '0 : merged_wide[VALUE_W-1:0];

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_accept) begin
      s1_v_nxt = (op_t'(in_operation) == OP_READ);
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (out_free) begin
      out_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_val_r <= value_nxt;
      out_bad_r <= bad_r;
    end
  end

  assign out_valid       = out_v_r;
  assign out_count_value = out_val_r;
  assign out_bad_index   = out_bad_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `PCP_ASSERT_IMPL(a_bad_gives_zero, clk, rst_n, out_valid && out_bad_index, out_count_value == '0)
  `PCP_ASSERT_NEXT(a_capture_on_read, clk, rst_n, in_valid && !in_stall, s1_v_r == $past(in_operation))
  `PCP_ASSERT_IMPL(a_back_pressure, clk, rst_n, s1_v_r && out_valid && out_stall, in_stall)
  `PCP_ASSERT_NEXT(a_sample_counts, clk, rst_n, samp_acc && (samp_cnt != '1), samp_cnt == ($past(samp_cnt) + COUNT_BITS'(1)))

endmodule
